// ----- rtl/prefix_code_bit_decoder_defines.svh -----
// ---------------------------------------------------------------------------
// prefix_code_bit_decoder_defines
// Assertion macros shared by the decoder RTL.
// ---------------------------------------------------------------------------
`ifndef PREFIX_CODE_BIT_DECODER_DEFINES_SVH
`define PREFIX_CODE_BIT_DECODER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PCBD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcbd assertion failed");

// next-cycle implication, checked out of reset
`define PCBD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcbd assertion failed");

`endif

// ----- rtl/pcbd_pkg.sv -----
// ---------------------------------------------------------------------------
// pcbd_pkg
// Constants and types of the prefix-code bit decoder.
// ---------------------------------------------------------------------------
package pcbd_pkg;

    localparam int MAX_CODE_LEN = 16;
    localparam int NUM_SYMBOLS  = 256;

    localparam int SYM_W  = 8;
    localparam int CODE_W = 16;
    localparam int LENF_W = 5;
    localparam int ACC_W  = MAX_CODE_LEN;
    localparam int CNT_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int IDX_W  = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int CMP_W  = (MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W;

    // priority pick: groups of cells resolved per stage
    localparam int GRP    = 16;
    localparam int GRP_W  = $clog2(GRP);
    localparam int NGRP   = (NUM_SYMBOLS + GRP - 1) / GRP;
    localparam int NGRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_DECODE = 1'b1;

    localparam logic STAT_OK    = 1'b0;
    localparam logic STAT_ERROR = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_GROUP,
        ST_FINAL
    } pcbd_state_t;

    typedef struct packed {
        logic              we;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code;
        logic [LENF_W-1:0] length;
    } pcbd_load_t;

    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic [CNT_W-1:0] count;
    } pcbd_probe_t;

endpackage

// ----- rtl/pcbd_if.sv -----
// ---------------------------------------------------------------------------
// pcbd_req_if / pcbd_rsp_if
// Valid/ready channels carrying request and result words.
// ---------------------------------------------------------------------------
interface pcbd_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [7:0]  load_symbol;
    logic [15:0] load_code;
    logic [4:0]  load_length;
    logic        code_bit;

    modport source (output valid, req_type, load_symbol, load_code, load_length, code_bit,
                    input ready);
    modport sink   (input valid, req_type, load_symbol, load_code, load_length, code_bit,
                    output ready);
endinterface

interface pcbd_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol_out;
    logic       status;

    modport source (output valid, symbol_out, status, input ready);
    modport sink   (input valid, symbol_out, status, output ready);
endinterface

// ----- rtl/pcbd_cell.sv -----
// ---------------------------------------------------------------------------
// pcbd_cell
// One table entry: stores code and length, compares against the accumulator.
// ---------------------------------------------------------------------------
module pcbd_cell
    import pcbd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] index,
    input  pcbd_load_t       load,
    input  pcbd_probe_t      probe,
    output logic             match
);

    logic              valid_reg;
    logic              valid_next;
    logic [CODE_W-1:0] code_reg;
    logic [LENF_W-1:0] len_reg;
    logic              match_reg;
    logic              match_next;
    logic              sel;
    logic [CODE_W-1:0] mask;

    assign sel        = load.we && (load.symbol == SYM_W'(index));
    assign mask       = ~({CODE_W{1'b1}} << load.length);
    assign valid_next = (load.length != '0) && (32'(load.length) <= MAX_CODE_LEN);
    assign match_next = valid_reg
                     && (32'(len_reg) == 32'(probe.count))
                     && (CMP_W'(code_reg) == CMP_W'(probe.acc));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            if (sel)
                valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel)
        begin
            code_reg <= load.code & mask;
            len_reg  <= load.length;
        end
    end

    assign match = match_reg;

endmodule

// ----- rtl/pcbd_pick.sv -----
// ---------------------------------------------------------------------------
// pcbd_pick
// Two-stage lowest-index pick over the cell match flags.
// ---------------------------------------------------------------------------
module pcbd_pick
    import pcbd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [NUM_SYMBOLS-1:0] match,
    output logic                   hit,
    output logic [IDX_W-1:0]       idx
);

    logic [NGRP*GRP-1:0] padded;
    logic [NGRP-1:0]     ghit_reg;
    logic [NGRP-1:0]     ghit_next;
    logic [GRP_W-1:0]    gidx_reg  [NGRP];
    logic [GRP_W-1:0]    gidx_next [NGRP];
    logic [NGRP_W-1:0]   gsel;

    assign padded = (NGRP*GRP)'(match);

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            ghit_next[g] = 1'b0;
            gidx_next[g] = '0;
            for (int b = GRP - 1; b >= 0; b--)
            begin
                if (padded[g*GRP + b])
                begin
                    ghit_next[g] = 1'b1;
                    gidx_next[g] = GRP_W'(b);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ghit_reg <= '0;
        else
            ghit_reg <= ghit_next;
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NGRP; g++)
            gidx_reg[g] <= gidx_next[g];
    end

    always_comb
    begin
        hit  = 1'b0;
        gsel = '0;
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (ghit_reg[g])
            begin
                hit  = 1'b1;
                gsel = NGRP_W'(g);
            end
        end
        idx = IDX_W'(32'(gsel) * GRP + 32'(gidx_reg[gsel]));
    end

endmodule

// ----- rtl/prefix_code_bit_decoder.sv -----
// ---------------------------------------------------------------------------
// prefix_code_bit_decoder
// Bit-serial prefix-code decoder with a loadable per-symbol code table.
// ---------------------------------------------------------------------------
// A load word writes the entry of one symbol when it is taken. A decode
// word steps through accumulate, compare in every table cell at once,
// then a two-stage lowest-symbol pick over the cell match flags; the result
// word (symbol, or error after MAX_CODE_LEN unmatched bits) leaves through an
// output register, and the next word is taken while it waits. The table is
// cleared by reset.
`include "prefix_code_bit_decoder_defines.svh"

module prefix_code_bit_decoder
    import pcbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    pcbd_req_if.sink   req,
    pcbd_rsp_if.source rsp
);

    pcbd_state_t      state_reg, state_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovld_reg, ovld_next;
    logic [SYM_W-1:0] osym_reg, osym_next;
    logic             ostat_reg, ostat_next;

    pcbd_load_t             load;
    pcbd_probe_t            probe;
    logic [NUM_SYMBOLS-1:0] match;
    logic                   hit;
    logic [IDX_W-1:0]       idx;
    logic                   acc_in;

    assign req.ready = (state_reg == ST_IDLE);
    assign acc_in    = req.valid && req.ready;

    assign load.we     = acc_in && (req.req_type == REQ_LOAD);
    assign load.symbol = req.load_symbol;
    assign load.code   = req.load_code;
    assign load.length = req.load_length;
    assign probe.acc   = acc_reg;
    assign probe.count = cnt_reg;

    for (genvar i = 0; i < NUM_SYMBOLS; i++)
    begin : g_cell
        pcbd_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .index (IDX_W'(i)),
            .load  (load),
            .probe (probe),
            .match (match[i])
        );
    end

    pcbd_pick u_pick (
        .clk   (clk),
        .rst_n (rst_n),
        .match (match),
        .hit   (hit),
        .idx   (idx)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        osym_reg  <= osym_next;
        ostat_reg <= ostat_next;
    end

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        ovld_next  = ovld_reg && !rsp.ready;
        osym_next  = osym_reg;
        ostat_next = ostat_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc_in && req.req_type == REQ_DECODE)
                begin
                    acc_next = (acc_reg << 1) | ACC_W'(req.code_bit);
                    if (32'(cnt_reg) < MAX_CODE_LEN)
                        cnt_next = cnt_reg + CNT_W'(1);
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH: state_next = ST_GROUP;
            ST_GROUP: state_next = ST_FINAL;
            ST_FINAL:
            begin
                if (!hit && 32'(cnt_reg) < MAX_CODE_LEN)
                    state_next = ST_IDLE;
                else if (!ovld_next)
                begin
                    // free result slot: emit and clear the accumulator
                    ovld_next  = 1'b1;
                    osym_next  = hit ? SYM_W'(idx) : '0;
                    ostat_next = hit ? STAT_OK : STAT_ERROR;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign rsp.valid      = ovld_reg;
    assign rsp.symbol_out = osym_reg;
    assign rsp.status     = ostat_reg;

    `PCBD_ASSERT_IMP(a_cnt_range, 1'b1, 32'(cnt_reg) <= MAX_CODE_LEN)
    `PCBD_ASSERT_NXT(a_decode_seq, acc_in && req.req_type == REQ_DECODE, state_reg == ST_MATCH)
    `PCBD_ASSERT_IMP(a_err_zero, ovld_reg && ostat_reg == STAT_ERROR, osym_reg == '0)
    `PCBD_ASSERT_IMP(a_rise_final, $rose(ovld_reg), $past(state_reg) == ST_FINAL)

endmodule

// ----- tb/sv/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the prefix-code bit decoder: table loads and
// decode bits with random idling, results checked against a predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
    import pcbd_pkg::*;
();

    typedef struct packed {
        logic        req_type;
        logic [7:0]  load_symbol;
        logic [15:0] load_code;
        logic [4:0]  load_length;
        logic        code_bit;
    } req_word_t;

    typedef struct packed {
        logic [7:0] symbol_out;
        logic       status;
    } rsp_word_t;

    // directed row: word, plus a typed-in result when it is obvious
    typedef struct packed {
        req_word_t w;
        logic      has_exp;
        rsp_word_t exp;
    } dir_row_t;

    logic clk;
    logic rst_n;
    bit   failed;

    pcbd_req_if req ();
    pcbd_rsp_if rsp ();

    prefix_code_bit_decoder u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req.sink),
        .rsp  (rsp.source)
    );

    // predictor state
    bit          tbl_valid [NUM_SYMBOLS];
    logic [15:0] tbl_code  [NUM_SYMBOLS];
    logic [4:0]  tbl_len   [NUM_SYMBOLS];
    logic [15:0] acc_bits;
    int          acc_cnt;

    rsp_word_t   pending_syms[$];
    int          src_idle_pct;
    int          snk_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void decode_predict(req_word_t w);
        rsp_word_t r;
        bit        hit;
        hit = 1'b0;
        r   = '0;
        if (w.req_type == REQ_LOAD)
        begin
            if (w.load_length == 0 || w.load_length > MAX_CODE_LEN)
            begin
                tbl_valid[w.load_symbol] = 1'b0;
            end
            else
            begin
                tbl_valid[w.load_symbol] = 1'b1;
                tbl_code[w.load_symbol]  =
                    16'(w.load_code & ((17'h1 << w.load_length) - 17'h1));
                tbl_len[w.load_symbol]   = w.load_length;
            end
        end
        else
        begin
            acc_bits = {acc_bits[14:0], w.code_bit};
            if (acc_cnt < MAX_CODE_LEN)
                acc_cnt++;
            for (int s = 0; s < NUM_SYMBOLS && !hit; s++)
            begin
                if (tbl_valid[s] && int'(tbl_len[s]) == acc_cnt && tbl_code[s] == acc_bits)
                begin
                    hit = 1'b1;
                    r.symbol_out = s[7:0];
                    r.status     = STAT_OK;
                end
            end
            if (!hit && acc_cnt >= MAX_CODE_LEN)
            begin
                hit = 1'b1;
                r.symbol_out = 8'd0;
                r.status     = STAT_ERROR;
            end
            if (hit)
            begin
                acc_bits = '0;
                acc_cnt  = 0;
                pending_syms.push_back(r);
            end
        end
    endfunction

    // entered and left at a falling edge; valid stays up between words unless the source idles
    task automatic send_word(req_word_t w);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid       <= 1'b1;
        req.req_type    <= w.req_type;
        req.load_symbol <= w.load_symbol;
        req.load_code   <= w.load_code;
        req.load_length <= w.load_length;
        req.code_bit    <= w.code_bit;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        decode_predict(w);
        @(negedge clk);
    endtask

    // result side
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        rsp_word_t e;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_syms.size() == 0)
            begin
                $error("unexpected result word sym=%0d status=%0d",
                       rsp.symbol_out, rsp.status);
                failed = 1'b1;
            end
            else
            begin
                e = pending_syms.pop_front();
                if (rsp.symbol_out !== e.symbol_out)
                begin
                    $error("symbol_out: expected %0d, got %0d", e.symbol_out, rsp.symbol_out);
                    failed = 1'b1;
                end
                if (rsp.status !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, rsp.status);
                    failed = 1'b1;
                end
            end
        end
    end

    function automatic req_word_t mk_load(int s, int c, int l);
        req_word_t w;
        w = '0;
        w.req_type    = REQ_LOAD;
        w.load_symbol = s[7:0];
        w.load_code   = c[15:0];
        w.load_length = l[4:0];
        w.code_bit    = 1'($urandom_range(1));
        return w;
    endfunction

    function automatic req_word_t mk_bit(int b);
        req_word_t w;
        w = req_word_t'($bits(req_word_t)'($urandom));
        w.req_type = REQ_DECODE;
        w.code_bit = b[0];
        return w;
    endfunction

    // stream the bits of a code held in the predictor table
    task automatic send_code(int s);
        for (int i = int'(tbl_len[s]) - 1; i >= 0; i--)
            send_word(mk_bit(int'(tbl_code[s][i])));
    endtask

    dir_row_t dir_tbl[$];

    task automatic add_row(req_word_t w, bit he = 1'b0, int sy = 0, bit st = 1'b0);
        dir_row_t r;
        r.w       = w;
        r.has_exp = he;
        r.exp     = {sy[7:0], st};
        dir_tbl.push_back(r);
    endtask

    initial
    begin
        int phase;
        int n;
        int s;
        req.valid       = 1'b0;
        req.req_type    = REQ_LOAD;
        req.load_symbol = '0;
        req.load_code   = '0;
        req.load_length = '0;
        req.code_bit    = 1'b0;
        rst_n           = 1'b0;
        src_idle_pct    = 0;
        snk_idle_pct    = 0;
        acc_bits        = '0;
        acc_cnt         = 0;
        foreach (tbl_valid[i])
            tbl_valid[i] = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty table: sixteen bits then error
        for (int i = 0; i < 15; i++)
            add_row(mk_bit(i & 1));
        add_row(mk_bit(1), 1'b1, 0, STAT_ERROR);
        add_row(mk_load(255, 16'hFFFF, 16));            // full-width code
        add_row(mk_load(7, 16'hFFFE, 1));               // code wider than length -> 0
        add_row(mk_load(3, 0, 1));                      // same code, lower symbol wins
        add_row(mk_bit(0), 1'b1, 3, STAT_OK);
        add_row(mk_load(3, 0, 0));                      // remove entry
        add_row(mk_bit(0), 1'b1, 7, STAT_OK);
        add_row(mk_load(7, 1, 17));                     // overlong length removes
        add_row(mk_load(0, 2'b11, 2));
        add_row(mk_bit(1));
        add_row(mk_bit(1), 1'b1, 0, STAT_OK);
        for (int i = 0; i < dir_tbl.size(); i++)
        begin
            send_word(dir_tbl[i].w);
            if (dir_tbl[i].has_exp && pending_syms.size() > 0)
                pending_syms[pending_syms.size() - 1] = dir_tbl[i].exp;
        end

        for (phase = 0; phase < 4; phase++)
        begin
            src_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 26 : 47) : 0;
            snk_idle_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 26 : 47) : 0;
            n = 0;
            while (n < 440)
            begin
                case ($urandom_range(9))
                    0, 1:
                    begin
                        send_word(mk_load($urandom_range(255), $urandom,
                                          ($urandom_range(9) == 0) ? $urandom_range(31)
                                                                   : $urandom_range(1, 8)));
                        n++;
                    end
                    2:
                    begin
                        send_word(mk_bit($urandom_range(1)));
                        n++;
                    end
                    default:
                    begin
                        s = $urandom_range(255);
                        if (tbl_valid[s] && acc_cnt == 0)
                        begin
                            send_code(s);
                            n += int'(tbl_len[s]);
                        end
                        else
                        begin
                            send_word(mk_bit($urandom_range(1)));
                            n++;
                        end
                    end
                endcase
            end
        end
        req.valid <= 1'b0;

        n = 0;
        while (pending_syms.size() != 0 && n < 100000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (20) @(posedge clk);
        if (!failed && pending_syms.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
